// File: src/mkslp_pkg.sv
`timescale 1ns / 1ps
package mkslp_pkg;

  localparam int TOUCH_W    = 12;
  localparam int TICK_W     = 8;
  localparam int COUNT_W    = 9;
  localparam int CODE_W     = 8;
  localparam int MAX_EVENTS = 12;
  localparam int EVC_W      = $clog2(MAX_EVENTS);
  localparam int MAP_SIZE   = 12;

  // Configuration register indexes.
  localparam logic REG_SHORT = 1'b0;
  localparam logic REG_LONG  = 1'b1;

  typedef struct packed {
    logic hit;
    logic is_long;
  } lane_ev_t;

  // Fixed keypad map; keys past the map report code zero.
  function automatic logic [CODE_W-1:0] key_code_of(input logic [3:0] key);
    logic [CODE_W-1:0] code;
    case (key)
      4'd0:    code = 8'h23;  // '#'
      4'd1:    code = 8'h39;  // '9'
      4'd2:    code = 8'h36;  // '6'
      4'd3:    code = 8'h31;  // '1'
      4'd4:    code = 8'h38;  // '8'
      4'd5:    code = 8'h30;  // '0'
      4'd6:    code = 8'h35;  // '5'
      4'd7:    code = 8'h32;  // '2'
      4'd8:    code = 8'h33;  // '3'
      4'd9:    code = 8'h34;  // '4'
      4'd10:   code = 8'h37;  // '7'
      4'd11:   code = 8'h2A;  // '*'
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

// File: src/mkslp_if.sv
`timescale 1ns / 1ps
interface mkslp_in_if;
  logic                         valid;
  logic                         ready;
  logic                         fresh_sample;
  logic [mkslp_pkg::TOUCH_W-1:0] touch_bits;

  modport source(output valid, fresh_sample, touch_bits, input ready);
  modport sink(input valid, fresh_sample, touch_bits, output ready);
endinterface

interface mkslp_out_if;
  logic                        valid;
  logic                        ready;
  logic [mkslp_pkg::CODE_W-1:0] key_code;
  logic                        long_press;
  logic                        last_event;

  modport source(output valid, key_code, long_press, last_event, input ready);
  modport sink(input valid, key_code, long_press, last_event, output ready);
endinterface

// File: src/multi_key_short_long_press_detector.sv
`timescale 1ns / 1ps
// Short/long press detector for a bank of touch keys.
// Each request on in_ch is one scan tick: fresh_sample loads touch_bits into
// the held touch status, otherwise the previous status is used again.
// Every key lane updates its press counter in the cycle the tick is taken.
// The events found are then sent on out_ch in ascending key order, one per
// cycle while the receiver is ready, each with the key's character, a
// long/short flag and a flag on the final event of the tick. A tick that
// causes no event produces nothing. Events pass the pending register and
// then the output register. A tick causes at most 12 events, which drain
// through the single output event register. The next tick is accepted in
// the cycle the last event of the previous one moves into the output
// register, so ticks without events go back to back. When the receiver
// stalls, the output register holds its event and the pending events wait;
// in_ch.ready stays low until they drain. Reset clears the held status, all
// counters and the event queue, and sets short_press_ticks to 2 and
// long_press_ticks to 50. cfg_we writes cfg_data to the register at cfg_idx;
// the user must do so only while the block idles; the block does not check.
module multi_key_short_long_press_detector #(
  parameter int NUM_KEYS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic                         cfg_idx,
  input  logic [mkslp_pkg::TICK_W-1:0] cfg_data,
  mkslp_in_if.sink                     in_ch,
  mkslp_out_if.source                  out_ch
);
  import mkslp_pkg::*;

  logic [TICK_W-1:0]  short_r;
  logic [TICK_W-1:0]  long_r;
  logic [TOUCH_W-1:0] held_r;
  logic [TOUCH_W-1:0] held_nxt;
  logic               accept;
  logic               load_ready;
  lane_ev_t           ev [NUM_KEYS];

  assign in_ch.ready = load_ready;
  assign accept      = in_ch.valid && load_ready;
  assign held_nxt    = in_ch.fresh_sample ? in_ch.touch_bits : held_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_r <= TICK_W'(2);
      long_r  <= TICK_W'(50);
      held_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_SHORT: short_r <= cfg_data;
          REG_LONG:  long_r  <= cfg_data;
          default:   ;
        endcase
      end
      if (accept) begin
        held_r <= held_nxt;
      end
    end
  end

  for (genvar g = 0; g < NUM_KEYS; g++) begin : g_lane
    logic touched;
    if (g < TOUCH_W) begin : g_map
      assign touched = held_nxt[g];
    end else begin : g_unmapped
      assign touched = 1'b0;
    end

    mkslp_lane u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .accept      (accept),
      .touched     (touched),
      .short_ticks (short_r),
      .long_ticks  (long_r),
      .ev          (ev[g])
    );
  end

  mkslp_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .ev         (ev),
    .load_ready (load_ready),
    .out_ch     (out_ch)
  );

endmodule

// File: src/mkslp_lane.sv
`timescale 1ns / 1ps
module mkslp_lane (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic                           touched,
  input  logic [mkslp_pkg::TICK_W-1:0]   short_ticks,
  input  logic [mkslp_pkg::TICK_W-1:0]   long_ticks,
  output mkslp_pkg::lane_ev_t            ev
);
  import mkslp_pkg::*;

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [COUNT_W-1:0] limit;
  logic [COUNT_W-1:0] long_ext;
  logic [COUNT_W-1:0] short_ext;

  assign limit     = {long_ticks, 1'b0};
  assign long_ext  = {1'b0, long_ticks};
  assign short_ext = {1'b0, short_ticks};

  always_comb begin
    ev = '0;
    if (touched) begin
      count_nxt  = (count_r < limit) ? count_r + COUNT_W'(1) : count_r;
      ev.hit     = (count_nxt == long_ext);
      ev.is_long = 1'b1;
    end else begin
      count_nxt  = '0;
      ev.hit     = (count_r >= short_ext) && (count_r < long_ext);
      ev.is_long = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

endmodule

// File: src/mkslp_merge.sv
`timescale 1ns / 1ps
module mkslp_merge #(
  parameter int NUM_KEYS = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  mkslp_pkg::lane_ev_t ev [NUM_KEYS],
  output logic                load_ready,
  mkslp_out_if.source         out_ch
);
  import mkslp_pkg::*;

  localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  logic [NUM_KEYS-1:0] pend_r, pend_nxt;
  logic [NUM_KEYS-1:0] plong_r;
  logic [EVC_W-1:0]    evc_r, evc_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0]   code_r;
  logic                long_r;
  logic                last_r;

  logic [KEY_W-1:0]    sel;
  logic [NUM_KEYS-1:0] sel_oh;
  logic [NUM_KEYS-1:0] rest;
  logic                pend_any;
  logic                move;
  logic                is_last;

  // Lowest pending key goes first, so events leave in key order.
  always_comb begin
    sel    = '0;
    sel_oh = '0;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        sel    = KEY_W'(i);
        sel_oh = '0;
        sel_oh[i] = 1'b1;
      end
    end
  end

  assign pend_any   = |pend_r;
  assign rest       = pend_r & ~sel_oh;
  assign move       = pend_any && (!out_valid_r || out_ch.ready);
  // A tick reports at most twelve events; the rest are dropped.
  assign is_last    = (rest == '0) || (evc_r == EVC_W'(MAX_EVENTS - 1));
  assign load_ready = !pend_any || (move && is_last);

  always_comb begin
    pend_nxt = pend_r;
    evc_nxt  = evc_r;
    if (load) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        pend_nxt[i] = ev[i].hit;
      end
      evc_nxt = '0;
    end else if (move) begin
      pend_nxt = is_last ? '0 : rest;
      evc_nxt  = evc_r + EVC_W'(1);
    end
    out_valid_nxt = move ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      evc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      evc_r       <= evc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        plong_r[i] <= ev[i].is_long;
      end
    end
    if (move) begin
      code_r <= key_code_of(4'(sel));
      long_r <= plong_r[sel];
      last_r <= is_last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.key_code   = code_r;
  assign out_ch.long_press = long_r;
  assign out_ch.last_event = last_r;

endmodule

// File: test/press_event_checker.sv
`timescale 1ns / 1ps
module press_event_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic                         cfg_idx,
  input  logic [mkslp_pkg::TICK_W-1:0] cfg_data,
  mkslp_in_if                          in_ch,
  mkslp_out_if                         out_ch,
  output int                           mismatches,
  output int                           events_due
);
  import mkslp_pkg::*;

  localparam int KEYS = 12;

  // Keypad characters, key 0 in the low byte.
  localparam logic [KEYS*CODE_W-1:0] KEYPAD = "*7432508169#";

  typedef struct {
    logic [CODE_W-1:0] code;
    logic              is_long;
    logic              last;
  } press_event_t;

  press_event_t       due_q[$];
  logic [TICK_W-1:0]  short_ticks;
  logic [TICK_W-1:0]  long_ticks;
  logic [TOUCH_W-1:0] held_bits;
  logic [COUNT_W-1:0] hold_count[KEYS];
  int                 errs = 0;

  task automatic report_mismatch(input string what);
    errs++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  function automatic void queue_event(input int key, input logic is_long);
    press_event_t ev;
    ev.code    = KEYPAD[key*CODE_W +: CODE_W];
    ev.is_long = is_long;
    ev.last    = 1'b0;
    due_q.push_back(ev);
  endfunction

  // Advances every key counter by one scan tick and queues the events it causes.
  function automatic void predict_tick(input logic fresh, input logic [TOUCH_W-1:0] bits);
    logic [COUNT_W-1:0] limit;
    logic [COUNT_W-1:0] c;
    int                 first;
    first = due_q.size();
    limit = {long_ticks, 1'b0};
    if (fresh) held_bits = bits;
    for (int k = 0; k < KEYS; k++) begin
      c = hold_count[k];
      if (held_bits[k]) begin
        if (c < limit) c = c + 1'b1;
        if (c == long_ticks) queue_event(k, 1'b1);
        hold_count[k] = c;
      end else begin
        // A release only reports a short press from inside the short window.
        if (c >= short_ticks && c < long_ticks) queue_event(k, 1'b0);
        hold_count[k] = '0;
      end
    end
    if (due_q.size() > first) due_q[due_q.size()-1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    press_event_t got;
    if (!rst_n) begin
      short_ticks = 8'd2;
      long_ticks  = 8'd50;
      held_bits   = '0;
      for (int k = 0; k < KEYS; k++) hold_count[k] = '0;
      due_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_q.size() == 0) begin
          report_mismatch($sformatf("unexpected event, key_code %h long_press %b",
                                    out_ch.key_code, out_ch.long_press));
        end else begin
          got = due_q.pop_front();
          if (out_ch.key_code !== got.code)
            report_mismatch($sformatf("key_code %h, expected %h", out_ch.key_code, got.code));
          if (out_ch.long_press !== got.is_long)
            report_mismatch($sformatf("long_press %b, expected %b for key_code %h",
                                      out_ch.long_press, got.is_long, got.code));
          if (out_ch.last_event !== got.last)
            report_mismatch($sformatf("last_event %b, expected %b for key_code %h",
                                      out_ch.last_event, got.last, got.code));
        end
      end
      if (in_ch.valid && in_ch.ready) predict_tick(in_ch.fresh_sample, in_ch.touch_bits);
      if (cfg_we) begin
        case (cfg_idx)
          REG_SHORT: short_ticks = cfg_data;
          REG_LONG:  long_ticks  = cfg_data;
          default: ;
        endcase
      end
    end
    mismatches <= errs;
    events_due <= due_q.size();
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
module tb;
  import mkslp_pkg::*;

  localparam int QUIET_CYCLES = 4;
  localparam int LONG_HOLD    = 200;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic               cfg_idx;
  logic [TICK_W-1:0]  cfg_data;
  int                 mismatches;
  int                 events_due;
  int                 hold_requests = 0;
  int                 holds_done = 0;
  bit                 tx_idle;
  bit                 rx_idle;
  logic [TOUCH_W-1:0] touch_now;

  mkslp_in_if  in_ch ();
  mkslp_out_if out_ch ();

  multi_key_short_long_press_detector dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  press_event_checker press_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mismatches (mismatches),
    .events_due (events_due)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic offer_tick(input logic fresh, input logic [TOUCH_W-1:0] bits);
    int gap;
    gap = tx_idle ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.fresh_sample <= fresh;
    in_ch.touch_bits   <= bits;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stops offering requests until every predicted event has been taken.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (events_due != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic set_times(input logic [TICK_W-1:0] short_t, input logic [TICK_W-1:0] long_t);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_SHORT;
    cfg_data <= short_t;
    @(posedge clk);
    cfg_idx  <= REG_LONG;
    cfg_data <= long_t;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Keys toggle a few at a time so that presses of many lengths occur; keys in
  // sticky stay held for the whole phase to reach long press times.
  task automatic run_phase(input logic [TICK_W-1:0] short_t, input logic [TICK_W-1:0] long_t,
                           input int count, input logic [TOUCH_W-1:0] sticky,
                           input bit idle, input bit squeeze);
    logic [TOUCH_W-1:0] flips;
    int                 roll;
    settle();
    set_times(short_t, long_t);
    tx_idle = idle;
    rx_idle = idle;
    if (squeeze) hold_requests++;
    for (int n = 0; n < count; n++) begin
      flips = '0;
      for (int k = 0; k < TOUCH_W; k++)
        if ($urandom_range(0, 4) == 0) flips[k] = 1'b1;
      roll = $urandom_range(0, 9);
      if (roll < 7) begin
        touch_now = (touch_now ^ flips) | sticky;
        offer_tick(1'b1, touch_now);
      end else if (roll < 9) begin
        // Without a fresh sample the touch bits carried here must not matter.
        offer_tick(1'b0, TOUCH_W'($urandom_range(0, 4095)));
      end else begin
        touch_now = TOUCH_W'($urandom_range(0, 4095)) | sticky;
        offer_tick(1'b1, touch_now);
      end
    end
  endtask

  initial begin : result_sink
    int gap;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (holds_done != hold_requests) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done++;
      end else begin
        gap = rx_idle ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        @(posedge clk);
        while (!out_ch.valid) @(posedge clk);
      end
    end
  end

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = REG_SHORT;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.fresh_sample = 1'b0;
    in_ch.touch_bits   = '0;
    tx_idle            = 1'b1;
    rx_idle            = 1'b1;
    touch_now          = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part with a short window of one tick and a long time of three.
    set_times(8'd2, 8'd3);
    offer_tick(1'b1, 12'hFFF);
    offer_tick(1'b0, 12'h000);
    offer_tick(1'b0, 12'hABC);  // all twelve keys hit the long time together
    offer_tick(1'b1, 12'hFFF);
    offer_tick(1'b1, 12'h000);  // release after a long press reports nothing
    offer_tick(1'b1, 12'hFFF);
    offer_tick(1'b1, 12'hFFF);
    offer_tick(1'b1, 12'h000);  // twelve short presses at once
    offer_tick(1'b1, 12'h555);
    offer_tick(1'b0, 12'hAAA);
    offer_tick(1'b1, 12'hAAA);
    offer_tick(1'b1, 12'h800);
    offer_tick(1'b1, 12'h001);
    offer_tick(1'b1, 12'h000);
    touch_now = '0;

    run_phase(8'd2,   8'd50,  60,  12'h008, 1'b1, 1'b0);
    run_phase(8'd1,   8'd1,   25,  12'h000, 1'b0, 1'b1);
    run_phase(8'd2,   8'd3,   25,  12'h000, 1'b0, 1'b0);
    run_phase(8'd3,   8'd8,   30,  12'h000, 1'b1, 1'b0);
    run_phase(8'd5,   8'd4,   25,  12'h000, 1'b1, 1'b0);
    run_phase(8'd4,   8'd4,   20,  12'h000, 1'b1, 1'b0);
    run_phase(8'd255, 8'd1,   20,  12'h000, 1'b1, 1'b0);
    run_phase(8'd1,   8'd255, 260, 12'h020, 1'b1, 1'b0);
    settle();

    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// File: filelist.f
src/mkslp_pkg.sv
src/mkslp_if.sv
src/mkslp_lane.sv
src/mkslp_merge.sv
src/multi_key_short_long_press_detector.sv
test/press_event_checker.sv
test/tb.sv
